[hw/rtl/sai_pkg.sv]
// Shared types and constants for the sorted array list.
`default_nettype none

package sai_pkg;

	// Operation codes carried in the request opcode field.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Status codes returned with every response.
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam int unsigned VALUE_IN_W = 16;
	localparam int unsigned COUNT_OUT_W = 6;

	typedef struct packed {
		logic                          opcode;
		logic signed [VALUE_IN_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [COUNT_OUT_W-1:0] count;
		logic                   empty_res;
		logic                   full_res;
	} rsp_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

[hw/rtl/sorted_array_insert_remove.sv]
// Top level of the sorted array list: controller, datapath and checks.
// The request is registered when it is taken, and the list, the response and its strobe
// are registered at the end of the execute state, in which every entry cell updates at once;
// busy is high in that state, so no new request is taken before the last one is through.
// Reset clears the count and the strobe; entries are undefined until written.
// The receiver cannot stall: each response is shown for exactly one cycle.
`default_nettype none

module sorted_array_insert_remove #(
	parameter int unsigned DEPTH       = 32,
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sai_pkg::req_t req,
	output logic          done,
	output sai_pkg::rsp_t rsp
);
	import sai_pkg::*;

	// Command bundle from the controller into the datapath.
	cmd_t cmd;

	// The controller takes a request when start is high in the idle state,
	// then enters the execute state, during which busy holds off new requests.
	sai_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// The datapath registers the request on load. In the execute cycle each
	// cell compares its entry with the value, and the cells from the insertion or
	// removal point on shift up for an insert or down for a remove in the same
	// edge. The response is registered at that edge and strobed with done in
	// the following cycle, in which the next request may also be taken.
	sai_dp #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// A response is only strobed once the controller is idle again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("response strobed while busy");

	// An accepted request always enters the execute cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not start execution");

	// Every execute cycle produces exactly one response strobe right after it.
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("execute cycle produced no response");

	// A dropped insert can only be reported while the list is full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == ST_FULL)) |-> rsp.full_res)
		else $error("full status without full flag");

endmodule

`default_nettype wire

[hw/rtl/sai_ctrl.sv]
// Controller state machine for the sorted array list.
`default_nettype none

module sai_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output sai_pkg::cmd_t cmd
);
	import sai_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		busy     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				busy     = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/sai_dp.sv]
// Datapath of the sorted array list: a row of entry cells with local compare and shift.
`default_nettype none

module sai_dp #(
	parameter int unsigned DEPTH       = 32,
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sai_pkg::cmd_t cmd,
	input  sai_pkg::req_t req,
	output logic          done,
	output sai_pkg::rsp_t rsp
);
	import sai_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	req_t                          req_q;
	logic [CNT_W-1:0]              count_q;
	logic                          done_q;
	rsp_t                          rsp_q;
	logic signed [VALUE_WIDTH-1:0] entry_q [DEPTH];

	logic signed [VALUE_WIDTH-1:0] val;
	logic [DEPTH-1:0]              gt;
	logic [DEPTH-1:0]              ge;
	logic [DEPTH-1:0]              eq;
	logic                          is_full;
	logic                          found;
	logic                          do_ins;
	logic                          do_rem;
	logic [CNT_W-1:0]              count_nxt;
	logic [1:0]                    status_nxt;

	// Sign-extend or truncate the request value to the stored width.
	assign val = VALUE_WIDTH'(req_q.value);

	assign is_full = (count_q == CNT_FULL);
	assign found   = |eq;
	assign do_ins  = cmd.exec && (req_q.opcode == OP_INSERT) && !is_full;
	assign do_rem  = cmd.exec && (req_q.opcode == OP_REMOVE) && found;

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_DONE;
		if (req_q.opcode == OP_INSERT) begin
			if (is_full) begin
				status_nxt = ST_FULL;
			end else begin
				count_nxt = count_q + CNT_W'(1);
			end
		end else begin
			if (found) begin
				count_nxt = count_q - CNT_W'(1);
			end else begin
				status_nxt = ST_NOT_FOUND;
			end
		end
	end

	// Each cell compares its own entry with the request value. The stored
	// entries are sorted, so the greater and greater-or-equal flags rise once
	// along the row and mark the insertion and removal points directly.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic                          valid;
		logic signed [VALUE_WIDTH-1:0] cell_nxt;

		assign valid = (IDX < count_q);
		assign gt[i] = valid && (entry_q[i] > val);
		assign ge[i] = valid && (entry_q[i] >= val);
		assign eq[i] = valid && (entry_q[i] == val);

		always_comb begin
			cell_nxt = entry_q[i];
			if (do_ins) begin
				if ((i > 0) && gt[(i > 0) ? i - 1 : 0]) begin
					cell_nxt = entry_q[(i > 0) ? i - 1 : 0];
				end else if (gt[i] || (IDX == count_q)) begin
					cell_nxt = val;
				end
			end else if (do_rem) begin
				if (ge[i] && (i < DEPTH - 1)) begin
					cell_nxt = entry_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end

		always_ff @(posedge clk) begin
			entry_q[i] <= cell_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			rsp_q.status    <= status_nxt;
			rsp_q.count     <= COUNT_OUT_W'(count_nxt);
			rsp_q.empty_res <= (count_nxt == '0);
			rsp_q.full_res  <= (count_nxt == CNT_FULL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) begin
				count_q <= count_nxt;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench for the sorted array list: random insert and remove traffic checked by a scoreboard.
`timescale 1ns / 1ps

module tb;
	import sai_pkg::*;

	localparam int unsigned LIST_DEPTH = 32;
	localparam int unsigned ITEMS_PER_PHASE = 150;
	// A correct block never goes this long without taking a request or answering one.
	localparam int unsigned STALL_LIMIT = 1000;

	// The scoreboard keeps its own sorted copy of the list and predicts the one
	// response that every request causes.
	class sorted_list_scoreboard;
		logic signed [15:0] held_values[$];
		rsp_t               expected_rsp[$];
		int unsigned        mismatches;
		int unsigned        failures;

		function void note_request(req_t r);
			rsp_t               e;
			logic signed [15:0] v;
			int                 pos;
			v = $signed(r.value);
			e.status = ST_DONE;
			if (r.opcode == OP_INSERT) begin
				// A full list drops the insert whatever the value.
				if (held_values.size() >= LIST_DEPTH) begin
					e.status = ST_FULL;
				end else begin
					// Go in ahead of the first larger value, so equal values keep
					// their arrival order.
					pos = held_values.size();
					for (int j = 0; j < held_values.size(); j++) begin
						if (held_values[j] > v) begin
							pos = j;
							break;
						end
					end
					held_values.insert(pos, v);
				end
			end else begin
				pos = -1;
				for (int j = 0; j < held_values.size(); j++) begin
					if (held_values[j] == v) begin
						pos = j;
						break;
					end
				end
				if (pos < 0) begin
					e.status = ST_NOT_FOUND;
				end else begin
					held_values.delete(pos);
				end
			end
			e.count     = COUNT_OUT_W'(held_values.size());
			e.empty_res = (held_values.size() == 0);
			e.full_res  = (held_values.size() >= LIST_DEPTH);
			expected_rsp.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (expected_rsp.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: response with no request waiting: status %0d count %0d",
						$realtime, got.status, got.count);
				end
			end else begin
				e = expected_rsp.pop_front();
				if (got.status !== e.status || got.count !== e.count ||
						got.empty_res !== e.empty_res || got.full_res !== e.full_res) begin
					failures++;
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: expected status %0d count %0d empty %b full %b,",
							$realtime, e.status, e.count, e.empty_res, e.full_res);
						$display("    got status %0d count %0d empty %b full %b",
							got.status, got.count, got.empty_res, got.full_res);
					end
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	sorted_list_scoreboard sb = new();

	// The random traffic alternates between filling the list and draining it, so
	// that full lists and empty lists both come up again and again.
	bit          filling = 1'b1;
	int unsigned idle_cycles = 0;

	sorted_array_insert_remove u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #6 clk = ~clk;

	// Every strobed response is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_response(rsp);
		end
	end

	// The watchdog restarts whenever a request is taken or a response comes out.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Drives one request and holds it until the block takes it. With the given
	// chance in a hundred the sender first sits idle with start low;
	// otherwise start stays high from the previous request.
	task automatic send_request(input req_t r, input int unsigned gap_pct);
		int unsigned gap;
		gap = ($urandom_range(99) < gap_pct) ? $urandom_range(5, 1) : 0;
		if (gap != 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic send_op(input logic op, input logic [15:0] v);
		req_t r;
		r.opcode = op;
		r.value  = v;
		send_request(r, 0);
	endtask

	// Values come from a narrow band around zero (to make duplicates), from the
	// extremes, or from the whole range.
	function automatic logic [15:0] random_value();
		int s;
		case ($urandom_range(3))
			0: begin
				s = $urandom_range(6);
				return 16'(s - 3);
			end
			1: begin
				case ($urandom_range(3))
					0: return 16'h7FFF;
					1: return 16'h8000;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic req_t random_request();
		req_t        r;
		int unsigned n;
		n = sb.held_values.size();
		// Switch direction a little after the list has gone full or empty, so that
		// some inserts hit a full list and some removes hit an empty one.
		if (filling && n >= LIST_DEPTH && $urandom_range(3) == 0) begin
			filling = 1'b0;
		end else if (!filling && n == 0 && $urandom_range(2) == 0) begin
			filling = 1'b1;
		end
		// A tenth of the traffic is plain noise.
		if ($urandom_range(99) < 10) begin
			r.opcode = 1'($urandom_range(1));
			r.value  = 16'($urandom);
			return r;
		end
		if ($urandom_range(99) < 85) begin
			r.opcode = filling ? OP_INSERT : OP_REMOVE;
		end else begin
			r.opcode = filling ? OP_REMOVE : OP_INSERT;
		end
		// Most removes name a value that is stored, often one of several copies.
		if (r.opcode == OP_REMOVE && n != 0 && $urandom_range(99) < 75) begin
			r.value = sb.held_values[$urandom_range(n - 1)];
		end else begin
			r.value = random_value();
		end
		return r;
	endfunction

	task automatic random_phase(input int unsigned gap_pct);
		for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
			send_request(random_request(), gap_pct);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: removes from an empty list, both extremes, duplicates at
		// both ends and in the middle, values that are not stored, and a drain back
		// down to empty.
		send_op(OP_REMOVE, 16'h0000);
		send_op(OP_INSERT, 16'h0000);
		send_op(OP_INSERT, 16'h7FFF);
		send_op(OP_INSERT, 16'h8000);
		send_op(OP_INSERT, 16'hFFFF);
		send_op(OP_INSERT, 16'h0001);
		send_op(OP_INSERT, 16'h0005);
		send_op(OP_INSERT, 16'h0005);
		send_op(OP_INSERT, 16'h8000);
		send_op(OP_INSERT, 16'h7FFF);
		send_op(OP_INSERT, 16'h5555);
		send_op(OP_INSERT, 16'hAAAA);
		send_op(OP_REMOVE, 16'h0064);
		send_op(OP_REMOVE, 16'h0005);
		send_op(OP_REMOVE, 16'h8000);
		send_op(OP_REMOVE, 16'h7FFF);
		send_op(OP_REMOVE, 16'h5555);
		send_op(OP_REMOVE, 16'hAAAA);
		send_op(OP_REMOVE, 16'h0000);
		send_op(OP_REMOVE, 16'hFFFF);
		send_op(OP_REMOVE, 16'h0001);
		send_op(OP_REMOVE, 16'h0005);
		send_op(OP_REMOVE, 16'h7FFF);
		send_op(OP_REMOVE, 16'h8000);
		send_op(OP_REMOVE, 16'h8000);

		// Random part: a sender that idles now and then, one that idles often,
		// and one that never idles.
		random_phase(15);
		random_phase(74);
		random_phase(0);

		@(negedge clk);
		start <= 1'b0;

		while (sb.expected_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		if (sb.failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
